@@ hdl/wwml_pkg.sv @@
// ----------------------------------------------------------------------------
// wwml_pkg
// Shared constants and types of the weighted window majority label block.
// ----------------------------------------------------------------------------
`default_nettype none

package wwml_pkg;

    localparam int NUM_LABELS_DEF = 256;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_WIN_DEF    = 16;

    localparam int LABEL_W  = 8;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 24;
    localparam int ROW_W    = 10;
    localparam int LW_REG_W = 11;
    localparam int WIN_REG_W = 5;
    localparam int PADDR_W  = 4;

    localparam logic [ROW_W-1:0] ROW_POS_MAX = 10'd1023;
    localparam logic [SUM_W-1:0] SUM_MAX     = 24'hFFFFFF;

    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] REG_WIN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_WIN_HEIGHT = 2'd2;

    localparam logic [LW_REG_W-1:0]  LINE_WIDTH_RST = 11'd1024;
    localparam logic [WIN_REG_W-1:0] WIN_WIDTH_RST  = 5'd3;
    localparam logic [WIN_REG_W-1:0] WIN_HEIGHT_RST = 5'd3;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_STORE,
        B_CELL_RD,
        B_HIST_RD,
        B_HIST_WR,
        B_SCAN,
        B_SCAN_LAST,
        B_OUT
    } t_back_state;

endpackage

`default_nettype wire

@@ hdl/wwml_queue.sv @@
// ----------------------------------------------------------------------------
// wwml_queue
// Two-entry word queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module wwml_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    logic [DATA_W-1:0] r_mem [0:1];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/wwml_front.sv @@
// ----------------------------------------------------------------------------
// wwml_front
// Track the raster position and turn each pixel into a window word.
// ----------------------------------------------------------------------------
`default_nettype none

module wwml_front #(
    parameter int MAX_WIDTH = wwml_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WIN   = wwml_pkg::MAX_WIN_DEF,
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int SW  = $clog2(MAX_WIN),
    localparam int NW  = $clog2(MAX_WIN + 1),
    localparam int TASK_W = wwml_pkg::LABEL_W + wwml_pkg::WEIGHT_W + SW + CW + 2*NW + 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic [wwml_pkg::LABEL_W-1:0]      i_pixel_label,
    input  wire logic [wwml_pkg::WEIGHT_W-1:0]     i_pixel_weight,
    input  wire logic                              i_frame_start,
    input  wire logic [wwml_pkg::LW_REG_W-1:0]     i_line_width,
    input  wire logic [wwml_pkg::WIN_REG_W-1:0]    i_win_width,
    input  wire logic [wwml_pkg::WIN_REG_W-1:0]    i_win_height,
    output logic [TASK_W-1:0]                      o_task
);

    localparam int CPW = (CW + 1 > NW) ? CW + 1 : NW;
    localparam int RPW = wwml_pkg::ROW_W + 1;

    logic [CW-1:0]               r_col;
    logic [wwml_pkg::ROW_W-1:0]  r_row;
    logic [SW-1:0]               r_slot;
    logic [CW-1:0]               n_col;
    logic [wwml_pkg::ROW_W-1:0]  n_row;
    logic [SW-1:0]               n_slot;

    logic [CW:0]                 lw_eff;
    logic [NW-1:0]               ww_eff;
    logic [NW-1:0]               wh_eff;
    logic [CW-1:0]               c0, c1;
    logic [wwml_pkg::ROW_W-1:0]  r0, r1;
    logic [SW-1:0]               s0, s1;
    logic                        wrap1, wrap2;
    logic [CW:0]                 c2;
    logic [CPW-1:0]              col_p1;
    logic [RPW-1:0]              row_p1;
    logic [NW-1:0]               kn, jn;
    logic                        full;

    function automatic logic [wwml_pkg::ROW_W-1:0] row_inc(
        input logic [wwml_pkg::ROW_W-1:0] r
    );
        return (r < wwml_pkg::ROW_POS_MAX) ? r + 1'b1 : r;
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(MAX_WIN - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb begin
        if (i_line_width == '0) begin
            lw_eff = (CW+1)'(1);
        end else if (i_line_width > MAX_WIDTH) begin
            lw_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            lw_eff = (CW+1)'(i_line_width);
        end
        if (i_win_width == '0) begin
            ww_eff = NW'(1);
        end else if (i_win_width > MAX_WIN) begin
            ww_eff = NW'(MAX_WIN);
        end else begin
            ww_eff = NW'(i_win_width);
        end
        if (i_win_height == '0) begin
            wh_eff = NW'(1);
        end else if (i_win_height > MAX_WIN) begin
            wh_eff = NW'(MAX_WIN);
        end else begin
            wh_eff = NW'(i_win_height);
        end

        c0 = i_frame_start ? '0 : r_col;
        r0 = i_frame_start ? '0 : r_row;
        s0 = i_frame_start ? '0 : r_slot;

        wrap1 = ({1'b0, c0} >= lw_eff);
        c1 = wrap1 ? '0 : c0;
        r1 = wrap1 ? row_inc(r0) : r0;
        s1 = wrap1 ? slot_inc(s0) : s0;

        c2 = {1'b0, c1} + 1'b1;
        wrap2 = (c2 >= lw_eff);
        n_col  = wrap2 ? '0 : c2[CW-1:0];
        n_row  = wrap2 ? row_inc(r1) : r1;
        n_slot = wrap2 ? slot_inc(s1) : s1;

        col_p1 = CPW'(c2);
        row_p1 = {1'b0, r1} + 1'b1;
        kn = (row_p1 < RPW'(wh_eff)) ? NW'(row_p1) : wh_eff;
        jn = (col_p1 < CPW'(ww_eff)) ? NW'(col_p1) : ww_eff;
        full = (kn == wh_eff) && (jn == ww_eff);

        o_task = {i_pixel_label, i_pixel_weight, s1, c1, kn, jn, full};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

endmodule

`default_nettype wire

@@ hdl/wwml_back.sv @@
// ----------------------------------------------------------------------------
// wwml_back
// Store the pixel, build the window histogram and scan it for the mode, zeroing it as the scan goes.
// ----------------------------------------------------------------------------
`default_nettype none

module wwml_back #(
    parameter int NUM_LABELS = wwml_pkg::NUM_LABELS_DEF,
    parameter int MAX_WIDTH  = wwml_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WIN    = wwml_pkg::MAX_WIN_DEF,
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int SW  = $clog2(MAX_WIN),
    localparam int NW  = $clog2(MAX_WIN + 1),
    localparam int TASK_W = wwml_pkg::LABEL_W + wwml_pkg::WEIGHT_W + SW + CW + 2*NW + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [TASK_W-1:0]             i_q_data,
    output logic                               o_q_pop,
    output logic                               o_clearing,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [wwml_pkg::LABEL_W-1:0]       o_mode_label,
    output logic                               o_window_full
);

    localparam int LBW   = $clog2(NUM_LABELS);
    localparam int AW    = SW + CW;
    localparam int DEPTH = MAX_WIN * (1 << CW);
    localparam int CELL_W = wwml_pkg::LABEL_W + wwml_pkg::WEIGHT_W;
    localparam int SUM_W = wwml_pkg::SUM_W;

    wwml_pkg::t_back_state r_state, n_state;

    logic [CELL_W-1:0] r_store [0:DEPTH-1];
    logic [SUM_W-1:0]  r_hist  [0:NUM_LABELS-1];

    logic [wwml_pkg::LABEL_W-1:0]  r_t_lab;
    logic [wwml_pkg::WEIGHT_W-1:0] r_t_wgt;
    logic [SW-1:0]                 r_t_slot;
    logic [CW-1:0]                 r_t_col;
    logic [NW-1:0]                 r_t_kn, r_t_jn;
    logic                          r_t_full;

    logic [NW-1:0]      r_k, r_j;
    logic [SW-1:0]      r_cs;
    logic [CW-1:0]      r_cc;
    logic               r_last;
    logic [CELL_W-1:0]  r_cell;
    logic [SUM_W-1:0]   r_hq;
    logic [LBW-1:0]     r_cnt;
    logic [LBW-1:0]     r_sidx;
    logic               r_scan_vld;
    logic [SUM_W-1:0]   r_best_sum;
    logic [LBW-1:0]     r_best_lab;
    logic               r_out_valid;
    logic [wwml_pkg::LABEL_W-1:0] r_out_lab;
    logic               r_out_full;

    logic               cnt_last;
    logic               st_we, st_re, h_we, h_re, out_load;
    logic [AW-1:0]      st_waddr, st_raddr;
    logic [LBW-1:0]     h_waddr, h_raddr;
    logic [SUM_W-1:0]   h_wdata;
    logic [LBW+wwml_pkg::LABEL_W-1:0] lab_ext, best_ext;
    logic               lab_ok;
    logic [SUM_W:0]     sum;

    assign cnt_last = (r_cnt == LBW'(NUM_LABELS - 1));
    assign lab_ext  = {{LBW{1'b0}}, r_cell[CELL_W-1:wwml_pkg::WEIGHT_W]};
    assign lab_ok   = (lab_ext < (LBW+wwml_pkg::LABEL_W)'(NUM_LABELS));
    assign best_ext = {{wwml_pkg::LABEL_W{1'b0}}, r_best_lab};
    assign sum      = {1'b0, r_hq} + (SUM_W+1)'(r_cell[wwml_pkg::WEIGHT_W-1:0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            wwml_pkg::B_CLEAR:     if (cnt_last) n_state = wwml_pkg::B_IDLE;
            wwml_pkg::B_IDLE:      if (i_q_valid) n_state = wwml_pkg::B_STORE;
            wwml_pkg::B_STORE:     n_state = wwml_pkg::B_CELL_RD;
            wwml_pkg::B_CELL_RD:   n_state = wwml_pkg::B_HIST_RD;
            wwml_pkg::B_HIST_RD:   n_state = wwml_pkg::B_HIST_WR;
            wwml_pkg::B_HIST_WR: begin
                n_state = r_last ? wwml_pkg::B_SCAN : wwml_pkg::B_CELL_RD;
            end
            wwml_pkg::B_SCAN:      if (cnt_last) n_state = wwml_pkg::B_SCAN_LAST;
            wwml_pkg::B_SCAN_LAST: n_state = wwml_pkg::B_OUT;
            wwml_pkg::B_OUT: begin
                if (!r_out_valid || i_ready) n_state = wwml_pkg::B_IDLE;
            end
            default:               n_state = wwml_pkg::B_CLEAR;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        o_clearing = 1'b0;
        st_we      = 1'b0;
        st_re      = 1'b0;
        h_we       = 1'b0;
        h_re       = 1'b0;
        out_load   = 1'b0;
        h_waddr    = r_cnt;
        h_raddr    = r_cnt;
        h_wdata    = '0;
        case (r_state)
            wwml_pkg::B_CLEAR: begin
                o_clearing = 1'b1;
                h_we       = 1'b1;
            end
            wwml_pkg::B_IDLE:    o_q_pop = i_q_valid;
            wwml_pkg::B_STORE:   st_we = 1'b1;
            wwml_pkg::B_CELL_RD: st_re = 1'b1;
            wwml_pkg::B_HIST_RD: begin
                h_re    = 1'b1;
                h_raddr = lab_ext[LBW-1:0];
            end
            wwml_pkg::B_HIST_WR: begin
                h_we    = lab_ok;
                h_waddr = lab_ext[LBW-1:0];
                h_wdata = sum[SUM_W] ? wwml_pkg::SUM_MAX : sum[SUM_W-1:0];
            end
            wwml_pkg::B_SCAN: begin
                h_re = 1'b1;
                h_we = 1'b1;
            end
            wwml_pkg::B_OUT:     out_load = !r_out_valid || i_ready;
            default:             o_clearing = 1'b0;
        endcase
    end

    assign st_waddr = {r_t_slot, r_t_col};
    assign st_raddr = {r_cs, r_cc};

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= {r_t_lab, r_t_wgt};
        end
        if (st_re) begin
            r_cell <= r_store[st_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hist[h_waddr] <= h_wdata;
        end
        if (h_re) begin
            r_hq <= r_hist[h_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wwml_pkg::B_CLEAR;
            r_cnt       <= '0;
            r_scan_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_vld <= (r_state == wwml_pkg::B_SCAN);
            if (r_state == wwml_pkg::B_CLEAR || r_state == wwml_pkg::B_SCAN) begin
                r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            {r_t_lab, r_t_wgt, r_t_slot, r_t_col, r_t_kn, r_t_jn, r_t_full} <= i_q_data;
        end
        if (r_state == wwml_pkg::B_STORE) begin
            r_k        <= '0;
            r_j        <= '0;
            r_cs       <= r_t_slot;
            r_cc       <= r_t_col;
            r_best_sum <= '0;
            r_best_lab <= '0;
        end
        if (r_state == wwml_pkg::B_HIST_RD) begin
            r_last <= (r_k == r_t_kn - 1'b1) && (r_j == r_t_jn - 1'b1);
            if (r_j == r_t_jn - 1'b1) begin
                r_j  <= '0;
                r_cc <= r_t_col;
                r_k  <= r_k + 1'b1;
                r_cs <= (r_cs == '0) ? SW'(MAX_WIN - 1) : r_cs - 1'b1;
            end else begin
                r_j  <= r_j + 1'b1;
                r_cc <= r_cc - 1'b1;
            end
        end
        if (r_state == wwml_pkg::B_SCAN) begin
            r_sidx <= r_cnt;
        end
        if (r_scan_vld && (r_hq > r_best_sum)) begin
            r_best_sum <= r_hq;
            r_best_lab <= r_sidx;
        end
        if (out_load) begin
            r_out_lab  <= best_ext[wwml_pkg::LABEL_W-1:0];
            r_out_full <= r_t_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_mode_label  = r_out_lab;
    assign o_window_full = r_out_full;

endmodule

`default_nettype wire

@@ hdl/weighted_window_majority_label.sv @@
// ----------------------------------------------------------------------------
// weighted_window_majority_label
// Weighted 2-D mode filter over a raster pixel stream with an APB register
// port.
// ----------------------------------------------------------------------------
// Per word: the back part stores the pixel, adds the weight of each cell of
//   the H*W window into the histogram, H and W the window size clipped at
//   the frame's top and left edges, then scans all NUM_LABELS entries for the mode.
// A word is done before the next is popped; the input queue holds two more words.
// Reset: synchronous, active low; a clearing pass over all NUM_LABELS entries
//   then zeroes the histogram, with no pixel accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_window_majority_label #(
    parameter int NUM_LABELS = wwml_pkg::NUM_LABELS_DEF,
    parameter int MAX_WIDTH  = wwml_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WIN    = wwml_pkg::MAX_WIN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [wwml_pkg::LABEL_W-1:0]   i_pixel_label,
    input  wire logic [wwml_pkg::WEIGHT_W-1:0]  i_pixel_weight,
    input  wire logic                           i_frame_start,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [wwml_pkg::LABEL_W-1:0]        o_mode_label,
    output logic                                o_window_full,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wwml_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = $clog2(MAX_WIN);
    localparam int NW = $clog2(MAX_WIN + 1);
    localparam int TASK_W = wwml_pkg::LABEL_W + wwml_pkg::WEIGHT_W + SW + CW + 2*NW + 1;

    logic [wwml_pkg::LW_REG_W-1:0]  r_line_width;
    logic [wwml_pkg::WIN_REG_W-1:0] r_win_width;
    logic [wwml_pkg::WIN_REG_W-1:0] r_win_height;

    logic              cfg_we;
    logic              in_accept;
    logic              q_full, q_valid, q_pop, clearing;
    logic [TASK_W-1:0] task_in, task_out;

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign o_ready   = !q_full && !clearing;
    assign in_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= wwml_pkg::LINE_WIDTH_RST;
            r_win_width  <= wwml_pkg::WIN_WIDTH_RST;
            r_win_height <= wwml_pkg::WIN_HEIGHT_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                wwml_pkg::REG_LINE_WIDTH: r_line_width <= pwdata[wwml_pkg::LW_REG_W-1:0];
                wwml_pkg::REG_WIN_WIDTH:  r_win_width  <= pwdata[wwml_pkg::WIN_REG_W-1:0];
                wwml_pkg::REG_WIN_HEIGHT: r_win_height <= pwdata[wwml_pkg::WIN_REG_W-1:0];
                default:                  r_win_height <= r_win_height;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            wwml_pkg::REG_LINE_WIDTH: prdata = 32'(r_line_width);
            wwml_pkg::REG_WIN_WIDTH:  prdata = 32'(r_win_width);
            wwml_pkg::REG_WIN_HEIGHT: prdata = 32'(r_win_height);
            default:                  prdata = '0;
        endcase
    end

    wwml_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WIN   (MAX_WIN)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_pixel_label  (i_pixel_label),
        .i_pixel_weight (i_pixel_weight),
        .i_frame_start  (i_frame_start),
        .i_line_width   (r_line_width),
        .i_win_width    (r_win_width),
        .i_win_height   (r_win_height),
        .o_task         (task_in)
    );

    wwml_queue #(
        .DATA_W (TASK_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (task_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (task_out)
    );

    wwml_back #(
        .NUM_LABELS (NUM_LABELS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WIN    (MAX_WIN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (task_out),
        .o_q_pop       (q_pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_mode_label  (o_mode_label),
        .o_window_full (o_window_full)
    );

endmodule

`default_nettype wire
